### hw/rtl/valve_timeout_controller_unit_assert.svh
// Assertion macros shared by the valve controller modules.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef VALVE_TIMEOUT_CONTROLLER_UNIT_ASSERT_SVH
`define VALVE_TIMEOUT_CONTROLLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/vtc_pkg.sv
package vtc_pkg;

  // Fixed field widths.
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned VIDX_W   = 3;
  localparam int unsigned LIMIT_W  = 24;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Reset values of the limit registers.
  localparam logic [LIMIT_W-1:0] OPEN_LIMIT_RST = 24'd60000;
  localparam logic [LIMIT_W-1:0] REST_LIMIT_RST = 24'd30000;

  // Depth of the frame queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_OPEN = 2'd1,
    MODE_REST = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_LIMIT = 2'd0,
    REG_REST_LIMIT = 2'd1
  } reg_idx_e;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

### hw/rtl/vtc_cmd_if.sv
interface vtc_cmd_if
  import vtc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VIDX_W-1:0]   valve_index;

  modport source (output valid, output opcode, output valve_index, input ready);
  modport sink   (input valid, input opcode, input valve_index, output ready);
endinterface

### hw/rtl/vtc_frame_if.sv
interface vtc_frame_if
  import vtc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              serial_bit;
  logic              latch_last;
  logic [MASK_W-1:0] open_mask;

  modport source (output valid, output serial_bit, output latch_last, output open_mask,
                  input ready);
  modport sink   (input valid, input serial_bit, input latch_last, input open_mask,
                  output ready);
endinterface

### hw/rtl/vtc_cfg_if.sv
interface vtc_cfg_if
  import vtc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [LIMIT_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/vtc_front.sv
`include "valve_timeout_controller_unit_assert.svh"

module vtc_front
  import vtc_pkg::*;
#(
  parameter int unsigned NUM_VALVES = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  vtc_cmd_if.sink           cmd_i,
  vtc_cfg_if.sink           cfg_i,
  input  q_stat_t           q_stat_i,
  output logic              push_o,
  output logic [MASK_W-1:0] push_mask_o
);

  logic [LIMIT_W-1:0] open_limit_q, rest_limit_q;
  mode_e              mode_q [NUM_VALVES];
  mode_e              mode_d [NUM_VALVES];
  logic [LIMIT_W-1:0] elapsed_q [NUM_VALVES];
  logic [LIMIT_W-1:0] elapsed_d [NUM_VALVES];
  logic [LIMIT_W-1:0] limit_c [NUM_VALVES];
  logic [LIMIT_W-1:0] count_c [NUM_VALVES];
  logic [MASK_W-1:0]  mask_q, mask_d;
  logic               accept;
  opcode_e            op;

  // An item is taken only when the queue can hold the frame it may cause.
  assign cmd_i.ready = !q_stat_i.full;
  assign cfg_i.ready = 1'b1;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign op          = opcode_e'(cmd_i.opcode);

  // Limit registers; unknown indices are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_limit_q <= OPEN_LIMIT_RST;
      rest_limit_q <= REST_LIMIT_RST;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_OPEN_LIMIT) begin
        open_limit_q <= cfg_i.data;
      end else if (cfg_i.index == REG_REST_LIMIT) begin
        rest_limit_q <= cfg_i.data;
      end
    end
  end

  // Saturating tick count of every valve against the limit of its mode.
  always_comb begin
    for (int i = 0; i < NUM_VALVES; i++) begin
      limit_c[i] = (mode_q[i] == MODE_OPEN) ? open_limit_q : rest_limit_q;
      count_c[i] = (elapsed_q[i] < limit_c[i]) ? elapsed_q[i] + 1'b1 : limit_c[i];
    end
  end

  // Next mode and counter of each valve for the item being accepted.
  always_comb begin
    for (int i = 0; i < NUM_VALVES; i++) begin
      mode_d[i]    = mode_q[i];
      elapsed_d[i] = elapsed_q[i];
      if (accept) begin
        unique case (op)
          OP_TICK: begin
            if (mode_q[i] == MODE_OPEN || mode_q[i] == MODE_REST) begin
              if (count_c[i] >= limit_c[i]) begin
                mode_d[i]    = (mode_q[i] == MODE_OPEN) ? MODE_REST : MODE_IDLE;
                elapsed_d[i] = '0;
              end else begin
                elapsed_d[i] = count_c[i];
              end
            end
          end
          OP_OPEN: begin
            if (cmd_i.valve_index == VIDX_W'(i) && mode_q[i] == MODE_IDLE) begin
              mode_d[i]    = MODE_OPEN;
              elapsed_d[i] = '0;
            end
          end
          OP_CLOSE: begin
            if (cmd_i.valve_index == VIDX_W'(i) && mode_q[i] == MODE_OPEN) begin
              mode_d[i]    = MODE_REST;
              elapsed_d[i] = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Open mask of the new state: valve i on bit i+1.
  always_comb begin
    mask_d = '0;
    for (int i = 0; i < NUM_VALVES; i++) begin
      mask_d[i+1] = (mode_d[i] == MODE_OPEN);
    end
  end

  assign push_o      = accept && (mask_d != mask_q);
  assign push_mask_o = mask_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VALVES; i++) begin
        mode_q[i]    <= MODE_IDLE;
        elapsed_q[i] <= '0;
      end
      mask_q <= '0;
    end else begin
      for (int i = 0; i < NUM_VALVES; i++) begin
        mode_q[i]    <= mode_d[i];
        elapsed_q[i] <= elapsed_d[i];
      end
      if (push_o) begin
        mask_q <= mask_d;
      end
    end
  end

  `VTC_ASSERT_NOW(a_mask_bit0_clear, 1'b1, mask_q[0] == 1'b0, "mask bit 0 set")
  `VTC_ASSERT_NEXT(a_push_changes_mask, push_o, mask_q != $past(mask_q),
                   "frame pushed without a change of mask")

endmodule

### hw/rtl/vtc_queue.sv
`include "valve_timeout_controller_unit_assert.svh"

module vtc_queue
  import vtc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [MASK_W-1:0] push_mask_i,
  input  logic              pop_i,
  output logic [MASK_W-1:0] pop_mask_o,
  output q_stat_t           q_stat_o
);

  logic [MASK_W-1:0] entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign q_stat_o.full      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign q_stat_o.not_empty = (count_q != '0);
  assign pop_mask_o         = entry_q[rd_ptr_q];

  // Payload storage; no reset needed.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_mask_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `VTC_ASSERT_NOW(a_no_push_full, push_i, !q_stat_o.full, "push into a full queue")
  `VTC_ASSERT_NOW(a_no_pop_empty, pop_i, q_stat_o.not_empty, "pop from an empty queue")

endmodule

### hw/rtl/vtc_back.sv
`include "valve_timeout_controller_unit_assert.svh"

module vtc_back
  import vtc_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  q_stat_t           q_stat_i,
  input  logic [MASK_W-1:0] pop_mask_i,
  output logic              pop_o,
  vtc_frame_if.source       frame_o
);

  localparam int unsigned CNT_W = $clog2(FRAME_BITS);

  logic                  valid_q;
  logic [MASK_W-1:0]     mask_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [CNT_W-1:0]      pos;
  logic [FRAME_BITS-1:0] frame;
  logic                  last;
  logic                  out_acc;

  // Frame bit k is mask bit FRAME_BITS-1-k; bits above the mask carry zero.
  assign frame = FRAME_BITS'(mask_q);
  assign pos   = CNT_W'(FRAME_BITS - 1) - cnt_q;
  assign last  = (cnt_q == CNT_W'(FRAME_BITS - 1));

  assign frame_o.valid      = valid_q;
  assign frame_o.serial_bit = frame[pos];
  assign frame_o.latch_last = last;
  assign frame_o.open_mask  = mask_q;

  assign out_acc = valid_q && frame_o.ready;
  assign pop_o   = q_stat_i.not_empty && (!valid_q || (out_acc && last));

  // Shifter: loads a frame from the queue and steps one bit per item taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      mask_q  <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      cnt_q   <= '0;
      mask_q  <= pop_mask_i;
    end else if (out_acc) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  `VTC_ASSERT_NEXT(a_bit_step, out_acc && !last, valid_q && cnt_q == $past(cnt_q) + 1'b1,
                   "frame did not step to the next bit")

endmodule

### hw/rtl/valve_timeout_controller_unit.sv
// An item acts on the valves at the edge that accepts it; a changed open mask is written
// into the frame queue, then loaded into the shifter once it is free, and shows its frame bits.
// Throughput: one item per cycle while the two-entry frame queue has room; each frame
// is sent as FRAME_BITS serial bits, which bounds the rate of items that change the mask.
// Reset: all valves idle, counters and mask zero, limits 60000 and 30000 ticks.
module valve_timeout_controller_unit
  import vtc_pkg::*;
#(
  parameter int unsigned NUM_VALVES = 5,
  parameter int unsigned FRAME_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vtc_cmd_if.sink     cmd_i,
  vtc_cfg_if.sink     cfg_i,
  vtc_frame_if.source frame_o
);

  q_stat_t           q_stat;
  logic              push;
  logic [MASK_W-1:0] push_mask;
  logic              pop;
  logic [MASK_W-1:0] pop_mask;

  // Command decode and valve state.
  vtc_front #(
    .NUM_VALVES(NUM_VALVES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .cfg_i      (cfg_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_mask_o(push_mask)
  );

  // Pending frames.
  vtc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_mask_i(push_mask),
    .pop_i      (pop),
    .pop_mask_o (pop_mask),
    .q_stat_o   (q_stat)
  );

  // Serial frame output.
  vtc_back #(
    .FRAME_BITS(FRAME_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .pop_mask_i(pop_mask),
    .pop_o     (pop),
    .frame_o   (frame_o)
  );

endmodule

### bench/tb_top.sv
module tb_top;
  import vtc_pkg::*;

  localparam int unsigned NVALVES          = 5;
  localparam int unsigned NBITS            = 8;
  localparam int unsigned VIDX_MAX         = (1 << VIDX_W) - 1;
  localparam int unsigned WATCHDOG_CYCLES  = 200000;
  localparam int unsigned SETTLE_CYCLES    = 12;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_PHASES    = 5;
  localparam int unsigned ITEMS_PER_PHASE  = 31;
  localparam int unsigned REPORT_LIMIT     = 10;

  // Codes that the package leaves unnamed but the fields can still carry.
  localparam logic [OPCODE_W-1:0]  OP_SPARE     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [LIMIT_W-1:0]   LIMIT_MAX    = '1;

  typedef struct packed {
    logic              sbit;
    logic              last;
    logic [MASK_W-1:0] mask;
  } frame_bit_t;

  typedef enum int unsigned {
    RX_STREAM,
    RX_COIN,
    RX_EVERY_FOURTH,
    RX_SPARSE
  } rx_style_e;

  // Tracks valve state and the frame bits that each accepted command should produce.
  class valve_frame_scoreboard;
    logic [LIMIT_W-1:0] open_limit;
    logic [LIMIT_W-1:0] rest_limit;
    mode_e              valve_mode[NVALVES];
    logic [LIMIT_W-1:0] elapsed[NVALVES];
    logic [MASK_W-1:0]  shown_mask;
    frame_bit_t         frame_bits_due[$];
    int unsigned        mismatches;
    int unsigned        frames_due;
    int unsigned        bits_seen;
    int unsigned        ticks;
    int unsigned        opens;
    int unsigned        closes;
    int unsigned        ignored;
    int unsigned        reg_writes;

    function new();
      open_limit = OPEN_LIMIT_RST;
      rest_limit = REST_LIMIT_RST;
      foreach (valve_mode[i]) begin
        valve_mode[i] = MODE_IDLE;
        elapsed[i]    = '0;
      end
      shown_mask = '0;
    endfunction

    function int unsigned pending();
      return frame_bits_due.size();
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_OPEN_LIMIT: open_limit = data;
        REG_REST_LIMIT: rest_limit = data;
        default: ;
      endcase
    endfunction

    // One tick for one valve: count up, saturate, and move on once the limit is met.
    // A zero limit is met straight away, so the valve moves on the first tick.
    function void age_valve(int unsigned i);
      logic [LIMIT_W-1:0] lim;
      mode_e              next_mode;
      if (valve_mode[i] == MODE_OPEN) begin
        lim       = open_limit;
        next_mode = MODE_REST;
      end else if (valve_mode[i] == MODE_REST) begin
        lim       = rest_limit;
        next_mode = MODE_IDLE;
      end else begin
        return;
      end
      if (elapsed[i] < lim) begin
        elapsed[i] = elapsed[i] + 1'b1;
      end else begin
        elapsed[i] = lim;
      end
      if (elapsed[i] >= lim) begin
        valve_mode[i] = next_mode;
        elapsed[i]    = '0;
      end
    endfunction

    function void note_command(logic [OPCODE_W-1:0] op, logic [VIDX_W-1:0] idx);
      logic [MASK_W-1:0] mask;
      mask = '0;
      if (op == OP_TICK) begin
        ticks++;
        for (int unsigned i = 0; i < NVALVES; i++) age_valve(i);
      end else if (op == OP_OPEN && idx < NVALVES && valve_mode[idx] == MODE_IDLE) begin
        opens++;
        valve_mode[idx] = MODE_OPEN;
        elapsed[idx]    = '0;
      end else if (op == OP_CLOSE && idx < NVALVES && valve_mode[idx] == MODE_OPEN) begin
        closes++;
        valve_mode[idx] = MODE_REST;
        elapsed[idx]    = '0;
      end else begin
        ignored++;
      end

      // A frame goes out only when the set of open valves has changed.
      foreach (valve_mode[i]) begin
        if (valve_mode[i] == MODE_OPEN) mask[i+1] = 1'b1;
      end
      if (mask == shown_mask) return;
      shown_mask = mask;
      frames_due++;
      for (int k = 0; k < NBITS; k++) begin
        frame_bits_due.push_back('{sbit: mask[NBITS-1-k], last: (k == NBITS - 1), mask: mask});
      end
    endfunction

    function void check_bit(frame_bit_t got);
      frame_bit_t want;
      bits_seen++;
      if (frame_bits_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Frame item with nothing expected: bit=%0b last=%0b mask=%02h",
                   got.sbit, got.last, got.mask);
        end
        return;
      end
      want = frame_bits_due.pop_front();
      if (got.sbit !== want.sbit || got.last !== want.last || got.mask !== want.mask) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display({"Frame item mismatch: expected bit=%0b last=%0b mask=%02h, ",
                    "got bit=%0b last=%0b mask=%02h"},
                   want.sbit, want.last, want.mask, got.sbit, got.last, got.mask);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned burst_left;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned settings_used = 0;

  vtc_cmd_if   cmd_if ();
  vtc_cfg_if   cfg_if ();
  vtc_frame_if frame_if ();

  valve_frame_scoreboard valve_sb = new();

  valve_timeout_controller_unit #(
    .NUM_VALVES(NVALVES),
    .FRAME_BITS(NBITS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .cfg_i  (cfg_if),
    .frame_o(frame_if)
  );

  always #10 clk_i = ~clk_i;

  // Sample every handshake at the rising edge; frame items are checked before the
  // command of the same edge is noted, since that command's frame starts later.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (frame_if.valid && frame_if.ready) begin
        valve_sb.check_bit('{sbit: frame_if.serial_bit, last: frame_if.latch_last,
                             mask: frame_if.open_mask});
      end
      if (cmd_if.valid && cmd_if.ready) valve_sb.note_command(cmd_if.opcode, cmd_if.valve_index);
      if (cfg_if.valid && cfg_if.ready) valve_sb.write_register(cfg_if.index, cfg_if.data);
    end
  end

  // Frame receiver: random stall styles in segments, plus long hold-offs on request.
  initial begin : frame_receiver
    int unsigned seg_left;
    rx_style_e   style;
    seg_left       = 0;
    style          = RX_STREAM;
    frame_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_asked != holds_done) begin
        frame_if.ready = 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk_i);
        holds_done++;
      end else begin
        if (seg_left == 0) begin
          style    = rx_style_e'($urandom_range(0, 3));
          seg_left = $urandom_range(4, 40);
        end
        seg_left--;
        case (style)
          RX_STREAM:       frame_if.ready = 1'b1;
          RX_COIN:         frame_if.ready = 1'($urandom_range(0, 1));
          RX_EVERY_FOURTH: frame_if.ready = (seg_left % 4 == 0);
          default:         frame_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Take the command channel down for a gap whose length is set by n.
  task automatic pause_sender(input int unsigned n);
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Offer one command and wait for it to be taken; gaps fall between bursts.
  task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [VIDX_W-1:0] idx);
    @(negedge clk_i);
    cmd_if.valid       = 1'b1;
    cmd_if.opcode      = op;
    cmd_if.valve_index = idx;
    do @(posedge clk_i); while (!cmd_if.ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
    end
  endtask

  // Mostly well-formed valve traffic, with some unused codes and out-of-range valves.
  task automatic send_random();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_cmd(OP_OPEN, VIDX_W'($urandom_range(0, NVALVES - 1)));
    end else if (pick < 65) begin
      send_cmd(OP_TICK, VIDX_W'($urandom_range(0, VIDX_MAX)));
    end else if (pick < 88) begin
      send_cmd(OP_CLOSE, VIDX_W'($urandom_range(0, NVALVES - 1)));
    end else if (pick < 94) begin
      send_cmd(OP_SPARE, VIDX_W'($urandom_range(0, VIDX_MAX)));
    end else begin
      send_cmd(($urandom_range(0, 1) != 0) ? OP_OPEN : OP_CLOSE,
               VIDX_W'($urandom_range(NVALVES, VIDX_MAX)));
    end
  endtask

  // Let every expected frame drain, then leave the block quiet before returning.
  task automatic settle();
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
    while (valve_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_limits(input logic [LIMIT_W-1:0] open_ticks,
                            input logic [LIMIT_W-1:0] rest_ticks);
    settle();
    write_reg(REG_OPEN_LIMIT, open_ticks);
    write_reg(REG_REST_LIMIT, rest_ticks);
    settings_used++;
  endtask

  initial begin : watchdog
    repeat (WATCHDOG_CYCLES) @(posedge clk_i);
    $display("Timed out after %0d cycles with %0d frame items outstanding.",
             WATCHDOG_CYCLES, valve_sb.pending());
    $display("** valve_timeout_controller_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    cmd_if.valid       = 1'b0;
    cmd_if.opcode      = OP_TICK;
    cmd_if.valve_index = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_OPEN_LIMIT;
    cfg_if.data        = '0;
    burst_left         = 3;
    rst_ni             = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset limits: open every valve, then repeated, out-of-range and unused commands.
    for (int v = 0; v < NVALVES; v++) send_cmd(OP_OPEN, VIDX_W'(v));
    send_cmd(OP_OPEN, VIDX_W'(NVALVES));
    send_cmd(OP_OPEN, VIDX_W'(VIDX_MAX));
    send_cmd(OP_OPEN, 3'd2);
    send_cmd(OP_SPARE, 3'd3);
    send_cmd(OP_CLOSE, 3'd6);
    send_cmd(OP_CLOSE, 3'd1);
    send_cmd(OP_OPEN, 3'd1);
    send_cmd(OP_TICK, VIDX_W'(VIDX_MAX));
    send_cmd(OP_CLOSE, 3'd0);

    // Lower the open limit beneath counters that have already run past it.
    set_limits(24'd12, 24'd1);
    repeat (3) send_cmd(OP_TICK, 3'd0);
    set_limits(24'd2, 24'd1);
    send_cmd(OP_TICK, 3'd0);
    send_cmd(OP_TICK, 3'd0);

    // Zero limits behave as a limit of one tick.
    set_limits('0, '0);
    send_cmd(OP_OPEN, 3'd3);
    send_cmd(OP_TICK, 3'd0);
    send_cmd(OP_TICK, 3'd0);
    send_cmd(OP_OPEN, 3'd3);
    send_cmd(OP_CLOSE, 3'd3);

    // Writes to the unused register slots must leave the limits alone.
    settle();
    write_reg(REG_SPARE_LO, LIMIT_W'($urandom_range(0, LIMIT_MAX)));
    write_reg(REG_SPARE_HI, LIMIT_MAX);

    // Random phases over several limit settings; two of them start under a long stall.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       set_limits(24'd1, 24'd1);
        1:       set_limits(24'd2, 24'd3);
        2:       set_limits(LIMIT_MAX, LIMIT_MAX);
        default: set_limits(LIMIT_W'($urandom_range(1, 6)), LIMIT_W'($urandom_range(1, 6)));
      endcase
      if (p == 1 || p == 3) holds_asked++;
      repeat (ITEMS_PER_PHASE) send_random();
    end

    settle();
    $display("Covered %0d commands (%0d ticks, %0d opens, %0d closes, %0d ignored),",
             valve_sb.ticks + valve_sb.opens + valve_sb.closes + valve_sb.ignored,
             valve_sb.ticks, valve_sb.opens, valve_sb.closes, valve_sb.ignored);
    $display("%0d limit settings, %0d frames in %0d frame items, %0d writes, %0d stalls.",
             settings_used, valve_sb.frames_due, valve_sb.bits_seen, valve_sb.reg_writes,
             holds_done);
    if (valve_sb.mismatches == 0 && valve_sb.pending() == 0) begin
      $display("** valve_timeout_controller_unit: PASSED **");
    end else begin
      $display("** valve_timeout_controller_unit: FAILED **");
    end
    $finish;
  end

endmodule
